// ===== rtl/tmsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsa_pkg: shared types and constants of the trimmed-mean sensor averager
// Field widths, derived datapath widths, microcode encoding and the program.
// ----------------------------------------------------------------------------
package tmsa_pkg;

    // Field widths.
    localparam int TEMP_W   = 12;
    localparam int HUMI_W   = 10;
    localparam int MEAN_W   = 16;
    localparam int CFG_W    = 11;
    localparam int CNT_CFG_W = 5;
    localparam int IDX_W    = 2;

    // Longest burst that the accumulators are sized for.
    localparam int MAX_SAMPLES = 16;

    // Derived widths.
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_T_W = TEMP_W + $clog2(MAX_SAMPLES);
    localparam int SUM_H_W = HUMI_W + $clog2(MAX_SAMPLES);
    localparam int TRIM_W  = SUM_T_W + 2;
    localparam int MAG_W   = TRIM_W - 1;
    localparam int NUM_W   = MAG_W + 5;
    localparam int DEN_W   = CNT_W + 1;
    localparam int STEP_W  = $clog2(NUM_W);
    localparam int RES_W   = NUM_W + 2;

    localparam int MIN_SAMPLES = 3;
    localparam int MEAN_LOW    = -20000;
    localparam int MEAN_HIGH   = 25000;

    // Reset values of the registers.
    localparam logic [CNT_CFG_W-1:0]  SAMPLE_COUNT_RST = CNT_CFG_W'(12);
    localparam logic signed [CFG_W-1:0] TEMP_OFF_RST   = '0;
    localparam logic signed [CFG_W-1:0] HUMI_OFF_RST   = -11'sd80;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_TEMP_OFFSET  = 2'd1,
        REG_HUMI_OFFSET  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    // Datapath operations of one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_TRIM,
        OP_PREP,
        OP_DIV,
        OP_FIN,
        OP_ZERO,
        OP_WAIT,
        OP_EMIT
    } op_t;

    // Branch conditions; a true condition loads the jump target.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_LAST,
        C_FAIL,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic {
        CH_TEMP = 1'b0,
        CH_HUMI = 1'b1
    } chan_t;

    typedef struct packed {
        op_t   op;
        chan_t chan;
        cond_t cond;
        pc_t   target;
    } ctl_word_t;

    // Status seen by the sequencer's branch logic.
    typedef struct packed {
        logic has_input;
        logic last;
        logic fail;
        logic div_busy;
        logic out_busy;
    } seq_status_t;

    // Status that the datapath reports.
    typedef struct packed {
        logic last;
        logic fail;
        logic div_busy;
    } dp_status_t;

    // Effective configuration handed to the datapath.
    typedef struct packed {
        logic [CNT_W-1:0]          n_eff;
        logic [CNT_W-1:0]          divisor;
        logic signed [CFG_W-1:0]   temp_off;
        logic signed [CFG_W-1:0]   humi_off;
    } dp_cfg_t;

    // Program addresses.
    localparam pc_t PC_IDLE   = 4'd0;
    localparam pc_t PC_CHECK  = 4'd1;
    localparam pc_t PC_FAILCK = 4'd2;
    localparam pc_t PC_TRIM_T = 4'd3;
    localparam pc_t PC_PREP_T = 4'd4;
    localparam pc_t PC_DIV_T  = 4'd5;
    localparam pc_t PC_FIN_T  = 4'd6;
    localparam pc_t PC_TRIM_H = 4'd7;
    localparam pc_t PC_PREP_H = 4'd8;
    localparam pc_t PC_DIV_H  = 4'd9;
    localparam pc_t PC_FIN_H  = 4'd10;
    localparam pc_t PC_ZERO   = 4'd11;
    localparam pc_t PC_WAIT   = 4'd12;
    localparam pc_t PC_EMIT   = 4'd13;

    // The control store.
    function automatic ctl_word_t ucode_rom(input pc_t pc);
        ctl_word_t w;
        begin
            w = '{OP_NOP, CH_TEMP, C_ALWAYS, PC_IDLE};
            case (pc)
                PC_IDLE:   w = '{OP_ACCEPT, CH_TEMP, C_NO_INPUT, PC_IDLE};
                PC_CHECK:  w = '{OP_NOP,    CH_TEMP, C_NOT_LAST, PC_IDLE};
                PC_FAILCK: w = '{OP_NOP,    CH_TEMP, C_FAIL,     PC_ZERO};
                PC_TRIM_T: w = '{OP_TRIM,   CH_TEMP, C_NEVER,    PC_IDLE};
                PC_PREP_T: w = '{OP_PREP,   CH_TEMP, C_NEVER,    PC_IDLE};
                PC_DIV_T:  w = '{OP_DIV,    CH_TEMP, C_DIV_BUSY, PC_DIV_T};
                PC_FIN_T:  w = '{OP_FIN,    CH_TEMP, C_NEVER,    PC_IDLE};
                PC_TRIM_H: w = '{OP_TRIM,   CH_HUMI, C_NEVER,    PC_IDLE};
                PC_PREP_H: w = '{OP_PREP,   CH_HUMI, C_NEVER,    PC_IDLE};
                PC_DIV_H:  w = '{OP_DIV,    CH_HUMI, C_DIV_BUSY, PC_DIV_H};
                PC_FIN_H:  w = '{OP_FIN,    CH_HUMI, C_ALWAYS,   PC_WAIT};
                PC_ZERO:   w = '{OP_ZERO,   CH_TEMP, C_NEVER,    PC_IDLE};
                PC_WAIT:   w = '{OP_WAIT,   CH_TEMP, C_OUT_BUSY, PC_WAIT};
                PC_EMIT:   w = '{OP_EMIT,   CH_TEMP, C_ALWAYS,   PC_IDLE};
                default:   w = '{OP_NOP,    CH_TEMP, C_ALWAYS,   PC_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/tmsa_seq.sv =====
// ----------------------------------------------------------------------------
// tmsa_seq: microcode sequencer
// Step counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module tmsa_seq
    import tmsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output ctl_word_t   ctl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign ctl = ucode_rom(pc_reg);

    always_comb begin
        case (ctl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !status.has_input;
            C_NOT_LAST: take = !status.last;
            C_FAIL:     take = status.fail;
            C_DIV_BUSY: take = status.div_busy;
            C_OUT_BUSY: take = status.out_busy;
            default:    take = 1'b1;
        endcase
        pc_next = take ? ctl.target : pc_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/tmsa_datapath.sv =====
// ----------------------------------------------------------------------------
// tmsa_datapath: accumulators, shared divider and result formatting
// Runs the operation named by the current control word.
// ----------------------------------------------------------------------------
module tmsa_datapath
    import tmsa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ctl_word_t                ctl,
    input  dp_cfg_t                  cfg,
    input  logic                     in_fire,
    input  logic signed [TEMP_W-1:0] temp_sample,
    input  logic [HUMI_W-1:0]        humi_sample,
    input  logic                     read_failed,
    output dp_status_t               status,
    output logic signed [MEAN_W-1:0] temp_mean,
    output logic signed [MEAN_W-1:0] humi_mean,
    output logic                     burst_error
);

    // Burst accumulators.
    logic [CNT_W-1:0]          seen_reg, seen_next;
    logic                      fail_reg, fail_next;
    logic signed [SUM_T_W-1:0] tsum_reg, tsum_next;
    logic signed [TEMP_W-1:0]  tlo_reg, tlo_next, thi_reg, thi_next;
    logic [SUM_H_W-1:0]        hsum_reg, hsum_next;
    logic [HUMI_W-1:0]         hlo_reg, hlo_next, hhi_reg, hhi_next;

    // Division and result registers.
    logic signed [TRIM_W-1:0]  trim_reg, trim_next;
    logic                      neg_reg, neg_next;
    logic [NUM_W-1:0]          quo_reg, quo_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [MEAN_W-1:0]  tres_reg, tres_next, hres_reg, hres_next;
    logic                      err_reg, err_next;

    // Combinational helpers.
    logic signed [TRIM_W-1:0]  trim_val;
    logic [MAG_W-1:0]          mag;
    logic [NUM_W-1:0]          num;
    logic [DEN_W:0]            rem_sh;
    logic [DEN_W:0]            diff;
    logic [DEN_W-1:0]          den;
    logic signed [RES_W-1:0]   q_signed;
    logic signed [RES_W-1:0]   off10;
    logic signed [RES_W-1:0]   res;
    logic signed [CFG_W-1:0]   off_sel;
    logic signed [MEAN_W-1:0]  res_sat;

    always_comb begin
        if (ctl.chan == CH_HUMI) begin
            trim_val = signed'(TRIM_W'(hsum_reg)) - signed'(TRIM_W'(hlo_reg))
                     - signed'(TRIM_W'(hhi_reg));
            off_sel  = cfg.humi_off;
        end else begin
            trim_val = TRIM_W'(tsum_reg) - TRIM_W'(tlo_reg) - TRIM_W'(thi_reg);
            off_sel  = cfg.temp_off;
        end

        // Magnitude times twenty plus the divisor gives round-half-up on
        // the quotient by twice the divisor.
        mag = trim_reg[TRIM_W-1] ? MAG_W'(-trim_reg) : MAG_W'(trim_reg);
        num = (NUM_W'(mag) << 4) + (NUM_W'(mag) << 2) + NUM_W'(cfg.divisor);

        den    = {cfg.divisor, 1'b0};
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den};

        q_signed = neg_reg ? -signed'(RES_W'(quo_reg)) : signed'(RES_W'(quo_reg));
        off10    = (RES_W'(off_sel) <<< 3) + (RES_W'(off_sel) <<< 1);
        res      = q_signed + off10;
        if (res < RES_W'(MEAN_LOW)) begin
            res_sat = MEAN_W'(MEAN_LOW);
        end else if (res > RES_W'(MEAN_HIGH)) begin
            res_sat = MEAN_W'(MEAN_HIGH);
        end else begin
            res_sat = MEAN_W'(res);
        end
    end

    always_comb begin
        seen_next = seen_reg;
        fail_next = fail_reg;
        tsum_next = tsum_reg;
        tlo_next  = tlo_reg;
        thi_next  = thi_reg;
        hsum_next = hsum_reg;
        hlo_next  = hlo_reg;
        hhi_next  = hhi_reg;
        trim_next = trim_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        tres_next = tres_reg;
        hres_next = hres_reg;
        err_next  = err_reg;

        case (ctl.op)
            OP_ACCEPT: begin
                if (in_fire) begin
                    if (seen_reg == '0) begin
                        tsum_next = SUM_T_W'(temp_sample);
                        hsum_next = SUM_H_W'(humi_sample);
                        tlo_next  = temp_sample;
                        thi_next  = temp_sample;
                        hlo_next  = humi_sample;
                        hhi_next  = humi_sample;
                    end else begin
                        tsum_next = tsum_reg + SUM_T_W'(temp_sample);
                        hsum_next = hsum_reg + SUM_H_W'(humi_sample);
                        if (temp_sample < tlo_reg) tlo_next = temp_sample;
                        if (temp_sample > thi_reg) thi_next = temp_sample;
                        if (humi_sample < hlo_reg) hlo_next = humi_sample;
                        if (humi_sample > hhi_reg) hhi_next = humi_sample;
                    end
                    fail_next = fail_reg | read_failed;
                    seen_next = seen_reg + 1'b1;
                end
            end
            OP_TRIM: begin
                trim_next = trim_val;
            end
            OP_PREP: begin
                neg_next  = trim_reg[TRIM_W-1];
                quo_next  = num;
                rem_next  = '0;
                step_next = '0;
            end
            OP_DIV: begin
                // One restoring step: a quotient bit enters from the bottom.
                if (!diff[DEN_W]) begin
                    rem_next = diff[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
            end
            OP_FIN: begin
                if (ctl.chan == CH_HUMI) begin
                    hres_next = res_sat;
                end else begin
                    tres_next = res_sat;
                end
                err_next = 1'b0;
            end
            OP_ZERO: begin
                tres_next = '0;
                hres_next = '0;
                err_next  = 1'b1;
            end
            OP_EMIT: begin
                seen_next = '0;
                fail_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            fail_reg <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            fail_reg <= fail_next;
        end
        tsum_reg <= tsum_next;
        tlo_reg  <= tlo_next;
        thi_reg  <= thi_next;
        hsum_reg <= hsum_next;
        hlo_reg  <= hlo_next;
        hhi_reg  <= hhi_next;
        trim_reg <= trim_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        tres_reg <= tres_next;
        hres_reg <= hres_next;
        err_reg  <= err_next;
    end

    assign status.last     = (seen_reg >= cfg.n_eff);
    assign status.fail     = fail_reg;
    assign status.div_busy = (step_reg != STEP_W'(NUM_W - 1));

    assign temp_mean   = tres_reg;
    assign humi_mean   = hres_reg;
    assign burst_error = err_reg;

endmodule

// ===== rtl/trimmed_mean_sensor_averager.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_sensor_averager: olympic trimmed mean of paired sensor samples
// A sample that does not close a burst passes the idle and check steps. For a
// closing sample each channel in turn runs trim, prepare, the one-bit-per-cycle
// restoring divider that the two channels share, and finish; the result then
// waits for a free output register, is emitted and the sample channel reopens.
// A burst with a failed read skips the divider; a held result stalls the wait step.
// Reset (aresetn low, synchronous) restores the register defaults, empties
// the burst and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module trimmed_mean_sensor_averager
    import tmsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Sample channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [11:0] temp_sample, [21:12] humi_sample
    input  logic                 s_tuser,   // [0] read_failed

    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [15:0] temp_mean, [31:16] humi_mean
    output logic                 m_tuser,   // [0] burst_error

    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    // Configuration registers. Index values outside the list are dropped.
    logic [CNT_CFG_W-1:0]      sample_count_reg;
    logic signed [CFG_W-1:0]   temp_off_reg;
    logic signed [CFG_W-1:0]   humi_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            temp_off_reg     <= TEMP_OFF_RST;
            humi_off_reg     <= HUMI_OFF_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_wr_index))
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wr_data[CNT_CFG_W-1:0];
                REG_TEMP_OFFSET:  temp_off_reg     <= cfg_wr_data;
                REG_HUMI_OFFSET:  humi_off_reg     <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // The burst length is clamped to the range the accumulators support;
    // the divisor is that length less the two trimmed extremes.
    dp_cfg_t cfg;
    always_comb begin
        if (sample_count_reg < CNT_CFG_W'(MIN_SAMPLES)) begin
            cfg.n_eff = CNT_W'(MIN_SAMPLES);
        end else if (CNT_W'(sample_count_reg) > CNT_W'(MAX_SAMPLES)) begin
            cfg.n_eff = CNT_W'(MAX_SAMPLES);
        end else begin
            cfg.n_eff = CNT_W'(sample_count_reg);
        end
        cfg.divisor  = cfg.n_eff - CNT_W'(2);
        cfg.temp_off = temp_off_reg;
        cfg.humi_off = humi_off_reg;
    end

    ctl_word_t   ctl;
    seq_status_t seq_status;
    dp_status_t  dp_status;
    logic        in_fire;

    logic signed [MEAN_W-1:0] temp_mean;
    logic signed [MEAN_W-1:0] humi_mean;
    logic                     burst_error;

    // The sample channel is open only in the sequencer's idle step.
    assign s_tready = (ctl.op == OP_ACCEPT);
    assign in_fire  = s_tvalid && s_tready;

    // Output register. The sequencer waits in its wait step until the
    // register is free, so the emit step always finds room for the result.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign seq_status.has_input = s_tvalid;
    assign seq_status.last      = dp_status.last;
    assign seq_status.fail      = dp_status.fail;
    assign seq_status.div_busy  = dp_status.div_busy;
    assign seq_status.out_busy  = m_tvalid_reg && !m_tready;

    tmsa_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (seq_status),
        .ctl     (ctl)
    );

    tmsa_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .cfg         (cfg),
        .in_fire     (in_fire),
        .temp_sample (signed'(s_tdata[TEMP_W-1:0])),
        .humi_sample (s_tdata[TEMP_W+HUMI_W-1:TEMP_W]),
        .read_failed (s_tuser),
        .status      (dp_status),
        .temp_mean   (temp_mean),
        .humi_mean   (humi_mean),
        .burst_error (burst_error)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.op == OP_EMIT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (ctl.op == OP_EMIT) begin
            m_tdata_reg <= {humi_mean, temp_mean};
            m_tuser_reg <= burst_error;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
